>>> src/ceq_pkg.sv
// Shared types and constants of the calendar event queue.
package ceq_pkg;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_POP    = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  // Register indexes, decoded from paddr[2].
  localparam logic REG_IDX_WIDTH = 1'b0;
  localparam logic REG_IDX_COUNT = 1'b1;

  localparam int unsigned FRAME_W       = 32;
  localparam int unsigned TAG_W         = 16;
  localparam int unsigned AGE_W         = 16;
  localparam int unsigned DIVIDEND_W    = 32;
  localparam int unsigned DIV_STEP_BITS = 8;
  localparam int unsigned DIV_STEPS     = DIVIDEND_W / DIV_STEP_BITS;
  localparam int unsigned DIV_CNT_W     = 2;

endpackage

>>> src/ceq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ceq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/ceq_rem.sv
// Multi-cycle remainder unit: a 32-bit dividend modulo a narrow divisor, 8 bits a cycle.
module ceq_rem #(
  parameter int unsigned DIVISOR_W = 9
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [ceq_pkg::DIVIDEND_W-1:0]   dividend,
  input  logic [DIVISOR_W-1:0]             divisor,
  output logic                             done,
  output logic [DIVISOR_W-1:0]             remainder
);

  localparam int unsigned DW = ceq_pkg::DIVIDEND_W;
  localparam int unsigned SB = ceq_pkg::DIV_STEP_BITS;
  localparam int unsigned CNTW = ceq_pkg::DIV_CNT_W;

  logic                 running_r;
  logic                 done_r;
  logic [DW-1:0]        dvd_r;
  logic [DIVISOR_W-1:0] rem_r;
  logic [CNTW-1:0]      step_r;
  logic [DIVISOR_W-1:0] rem_nxt;
  logic [DIVISOR_W:0]   trial;
  logic                 last_step;

  // Restoring remainder: the partial remainder stays below the divisor.
  always_comb begin
    rem_nxt = rem_r;
    trial   = '0;
    for (int k = 0; k < SB; k++) begin
      trial = {rem_nxt, dvd_r[DW-1-k]};
      if (trial >= {1'b0, divisor}) begin
        trial = trial - {1'b0, divisor};
      end
      rem_nxt = trial[DIVISOR_W-1:0];
    end
  end

  assign last_step = (step_r == CNTW'(ceq_pkg::DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      done_r    <= 1'b0;
      step_r    <= '0;
    end else begin
      done_r <= !start && running_r && last_step;
      if (start) begin
        running_r <= 1'b1;
        dvd_r     <= dividend;
        rem_r     <= '0;
        step_r    <= '0;
      end else if (running_r) begin
        rem_r  <= rem_nxt;
        dvd_r  <= dvd_r << SB;
        step_r <= step_r + CNTW'(1);
        if (last_step) begin
          running_r <= 1'b0;
        end
      end
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

>>> src/calendar_event_queue.sv
// Top level of the calendar event queue: sequencer, slot store and registers.
//
//  channel  | handshake            | words
//  ---------+----------------------+------------------------------------------------
//  in_      | in_valid / in_ready  | kind, event_time, event_tag
//  out_     | out_valid / out_ready| status, popped_time, popped_tag, queue_size, frame_now
//  config   | APB psel/penable     | bucket_width_log2 (0x0), number of buckets (0x4)
//
// An insert, removal or pop is handled by walking the slots, one slot at a time
// through the single read port of the slot RAM; an insert stops at the first free
// slot. During a pop, a slot whose frame lies behind the current frame also needs
// the shared remainder unit.
// Reset is synchronous and empties the store; no clearing pass is needed.
// A new word is taken while an earlier result still waits on out_ready.
module calendar_event_queue #(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned MAX_BUCKETS = 256,
  parameter int unsigned TIME_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_event_time,
  input  logic [15:0] in_event_tag,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_popped_time,
  output logic [15:0] out_popped_tag,
  output logic [6:0]  out_queue_size,
  output logic [31:0] out_frame_now,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned TW  = (TIME_BITS < 32) ? TIME_BITS : 32;
  localparam int unsigned AW  = $clog2(CAPACITY);
  localparam int unsigned HW  = $clog2(CAPACITY + 1);
  localparam int unsigned CW  = $clog2(MAX_BUCKETS + 1);
  localparam int unsigned FW  = ceq_pkg::FRAME_W;
  localparam int unsigned GW  = ceq_pkg::TAG_W;
  localparam int unsigned OW  = ceq_pkg::AGE_W;
  localparam int unsigned RW  = TW + GW + OW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EVAL,
    S_DIV,
    S_DONE
  } state_t;

  state_t               state_r;
  logic [4:0]           width_r;
  logic [8:0]           count_r;

  logic [CAPACITY-1:0]  valid_r;
  logic [HW-1:0]        held_r;
  logic [FW-1:0]        frame_r;
  logic [OW-1:0]        stamp_r;

  ceq_pkg::kind_t       op_kind_r;
  logic [TW-1:0]        op_time_r;
  logic [GW-1:0]        op_tag_r;
  logic [AW-1:0]        slot_r;

  logic                 best_found_r;
  logic [AW-1:0]        best_slot_r;
  logic [FW:0]          best_frame_r;
  logic [TW-1:0]        best_time_r;
  logic [GW-1:0]        best_tag_r;
  logic [OW-1:0]        best_age_r;

  logic                 out_valid_r;
  ceq_pkg::status_t     out_status_r;
  logic [31:0]          out_time_r;
  logic [GW-1:0]        out_tag_r;
  logic [6:0]           out_size_r;
  logic [FW-1:0]        out_frame_r;

  logic [RW-1:0]        rd_data;
  logic                 ram_we;
  logic [TW-1:0]        cur_time;
  logic [GW-1:0]        cur_tag;
  logic [OW-1:0]        cur_age;
  logic [TW-1:0]        cur_q;
  logic                 q_ahead;
  logic [CW-1:0]        cnt_eff;
  logic                 div_start;
  logic                 div_done;
  logic [CW-1:0]        div_rem;
  logic [CW-1:0]        adj;
  logic [FW:0]          cand_fr;
  logic                 pop_better;
  logic                 rem_better;
  logic                 last_slot;
  logic                 out_free;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == ceq_pkg::REG_IDX_COUNT) ? 32'(count_r) : 32'(width_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= '0;
      count_r <= 9'd256;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == ceq_pkg::REG_IDX_COUNT) begin
        count_r <= pwdata[8:0];
      end else begin
        width_r <= pwdata[4:0];
      end
    end
  end

  always_comb begin
    if (count_r == '0) begin
      cnt_eff = CW'(1);
    end else if (32'(count_r) > 32'(MAX_BUCKETS)) begin
      cnt_eff = CW'(MAX_BUCKETS);
    end else begin
      cnt_eff = CW'(count_r);
    end
  end

  // Slot store: time, tag and insertion stamp in one word.
  ceq_ram #(
    .WIDTH (RW),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (best_slot_r),
    .wdata ({op_time_r, op_tag_r, stamp_r}),
    .raddr (slot_r),
    .rdata (rd_data)
  );

  assign cur_time = rd_data[RW-1:GW+OW];
  assign cur_tag  = rd_data[GW+OW-1:OW];
  assign cur_age  = stamp_r - rd_data[OW-1:0];
  assign cur_q    = cur_time >> width_r;
  assign q_ahead  = 32'(cur_q) >= frame_r;

  // A slot whose frame lies behind the current one lands on the earliest frame at or
  // after it that maps to the same bucket; that distance needs (frame - q) mod count.
  ceq_rem #(
    .DIVISOR_W (CW)
  ) u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (frame_r - 32'(cur_q)),
    .divisor   (cnt_eff),
    .done      (div_done),
    .remainder (div_rem)
  );

  assign div_start = (state_r == S_EVAL) && (op_kind_r == ceq_pkg::KIND_POP) && !q_ahead;
  assign adj       = (div_rem == '0) ? '0 : (cnt_eff - div_rem);
  assign cand_fr   = (state_r == S_DIV) ? ({1'b0, frame_r} + (FW + 1)'(adj))
                                        : (FW + 1)'(cur_q);

  assign pop_better = !best_found_r || (cand_fr < best_frame_r) ||
                      ((cand_fr == best_frame_r) &&
                       ((cur_time < best_time_r) ||
                        ((cur_time == best_time_r) && (cur_age > best_age_r))));
  assign rem_better = (cur_time == op_time_r) && (cur_tag == op_tag_r) &&
                      (!best_found_r || (cur_age > best_age_r));

  assign last_slot = (slot_r == AW'(CAPACITY - 1));
  assign out_free  = !out_valid_r || out_ready;
  assign ram_we    = (state_r == S_DONE) && out_free &&
                     (op_kind_r == ceq_pkg::KIND_INSERT) && best_found_r;

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      held_r       <= '0;
      frame_r      <= '0;
      stamp_r      <= '0;
      out_valid_r  <= 1'b0;
      best_found_r <= 1'b0;
      slot_r       <= '0;
    end else begin
      // The closing state reloads the result register itself.
      if (out_valid_r && out_ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_kind_r    <= ceq_pkg::kind_t'(in_kind);
            op_time_r    <= TW'(in_event_time);
            op_tag_r     <= in_event_tag;
            slot_r       <= '0;
            best_found_r <= 1'b0;
            state_r      <= (ceq_pkg::kind_t'(in_kind) == ceq_pkg::KIND_NONE) ? S_DONE
                                                                              : S_SCAN;
          end
        end
        S_SCAN: begin
          if (op_kind_r == ceq_pkg::KIND_INSERT) begin
            if (!valid_r[slot_r]) begin
              best_found_r <= 1'b1;
              best_slot_r  <= slot_r;
              state_r      <= S_DONE;
            end else if (last_slot) begin
              state_r <= S_DONE;
            end else begin
              slot_r <= slot_r + AW'(1);
            end
          end else if (valid_r[slot_r]) begin
            state_r <= S_EVAL;
          end else if (last_slot) begin
            state_r <= S_DONE;
          end else begin
            slot_r <= slot_r + AW'(1);
          end
        end
        S_EVAL, S_DIV: begin
          if ((state_r == S_EVAL) && (op_kind_r == ceq_pkg::KIND_POP) && !q_ahead) begin
            state_r <= S_DIV;
          end else if ((state_r == S_EVAL) || div_done) begin
            if ((op_kind_r == ceq_pkg::KIND_POP) ? pop_better : rem_better) begin
              best_found_r <= 1'b1;
              best_slot_r  <= slot_r;
              best_frame_r <= cand_fr;
              best_time_r  <= cur_time;
              best_tag_r   <= cur_tag;
              best_age_r   <= cur_age;
            end
            if (last_slot) begin
              state_r <= S_DONE;
            end else begin
              slot_r  <= slot_r + AW'(1);
              state_r <= S_SCAN;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
            case (op_kind_r)
              ceq_pkg::KIND_INSERT: begin
                out_time_r  <= '0;
                out_tag_r   <= '0;
                out_frame_r <= frame_r;
                if (best_found_r) begin
                  valid_r[best_slot_r] <= 1'b1;
                  held_r               <= held_r + HW'(1);
                  stamp_r              <= stamp_r + OW'(1);
                  out_status_r         <= ceq_pkg::ST_OK;
                  out_size_r           <= 7'(held_r + HW'(1));
                end else begin
                  out_status_r <= ceq_pkg::ST_FULL;
                  out_size_r   <= 7'(held_r);
                end
              end
              ceq_pkg::KIND_REMOVE: begin
                out_time_r  <= '0;
                out_tag_r   <= '0;
                out_frame_r <= frame_r;
                if (best_found_r) begin
                  valid_r[best_slot_r] <= 1'b0;
                  held_r               <= held_r - HW'(1);
                  out_status_r         <= ceq_pkg::ST_OK;
                  out_size_r           <= 7'(held_r - HW'(1));
                end else begin
                  out_status_r <= ceq_pkg::ST_NOT_FOUND;
                  out_size_r   <= 7'(held_r);
                end
              end
              ceq_pkg::KIND_POP: begin
                if (best_found_r) begin
                  valid_r[best_slot_r] <= 1'b0;
                  held_r               <= held_r - HW'(1);
                  frame_r              <= best_frame_r[FW-1:0];
                  out_status_r         <= ceq_pkg::ST_OK;
                  out_size_r           <= 7'(held_r - HW'(1));
                  out_frame_r          <= best_frame_r[FW-1:0];
                  out_time_r           <= 32'(best_time_r);
                  out_tag_r            <= best_tag_r;
                end else begin
                  out_status_r <= ceq_pkg::ST_EMPTY;
                  out_size_r   <= 7'(held_r);
                  out_frame_r  <= frame_r;
                  out_time_r   <= '0;
                  out_tag_r    <= '0;
                end
              end
              default: begin
                out_status_r <= ceq_pkg::ST_OK;
                out_size_r   <= 7'(held_r);
                out_frame_r  <= frame_r;
                out_time_r   <= '0;
                out_tag_r    <= '0;
              end
            endcase
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_popped_time = out_time_r;
  assign out_popped_tag  = out_tag_r;
  assign out_queue_size  = out_size_r;
  assign out_frame_now   = out_frame_r;

  // The fill count always matches the number of occupied slots.
  a_held_matches: assert property (@(posedge clk) disable iff (!rst_n)
    int'(held_r) == $countones(valid_r))
    else $error("held count differs from occupied slots");

  // The remainder unit only finishes while the sequencer waits on it.
  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("remainder finished outside the wait state");

  // A result appears only when the sequencer closes a word.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result raised outside the closing state");

  // A new word is never taken while the sequencer is busy.
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_SCAN || state_r == S_DONE))
    else $error("accepted word did not start a scan");

endmodule

>>> verif/calendar_event_queue_tb.sv
// Self-checking testbench of the calendar event queue with its own prediction of every result.
`timescale 1ns / 100ps

module calendar_event_queue_tb;

  localparam int unsigned SLOTS       = 64;
  localparam int unsigned BUCKETS_MAX = 256;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam logic [2:0]  ADDR_WIDTH  = {ceq_pkg::REG_IDX_WIDTH, 2'b00};
  localparam logic [2:0]  ADDR_COUNT  = {ceq_pkg::REG_IDX_COUNT, 2'b00};

  typedef struct packed {
    ceq_pkg::kind_t kind;
    logic [31:0]    tstamp;
    logic [15:0]    tag;
  } op_word_t;

  typedef struct packed {
    ceq_pkg::status_t status;
    logic [31:0]      ptime;
    logic [15:0]      ptag;
    logic [6:0]       size;
    logic [31:0]      frame;
  } answer_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_kind;
  logic [31:0] in_event_time;
  logic [15:0] in_event_tag;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [31:0] out_popped_time;
  logic [15:0] out_popped_tag;
  logic [6:0]  out_queue_size;
  logic [31:0] out_frame_now;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  calendar_event_queue u_top (.*);

  // Shadow of the event store and the registers.
  logic [31:0] ev_time [SLOTS];
  logic [15:0] ev_tag [SLOTS];
  logic [15:0] ev_order [SLOTS];
  bit          ev_held [SLOTS];
  logic [6:0]  held_total;
  logic [31:0] cur_frame;
  logic [15:0] next_stamp;
  logic [4:0]  width_log2;
  logic [8:0]  count_reg;

  op_word_t    pending_ops[$];
  answer_t     awaited[$];
  op_word_t    history[$];
  int unsigned snd_idle;
  int unsigned rcv_idle;
  int unsigned errors;
  int unsigned cycles;
  logic        in_taken;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [15:0] age(int s);
    return next_stamp - ev_order[s];
  endfunction

  function automatic answer_t queue_op(op_word_t w);
    answer_t a;
    int best;
    longint unsigned cnt, f0, r, q, b, fb, fr, best_fr;
    a = '{status: ceq_pkg::ST_OK, ptime: '0, ptag: '0, size: '0, frame: '0};
    best = -1;
    best_fr = 0;
    case (w.kind)
      ceq_pkg::KIND_INSERT: begin
        for (int s = 0; s < SLOTS; s++) begin
          if (!ev_held[s] && best < 0) best = s;
        end
        if (best < 0) begin
          a.status = ceq_pkg::ST_FULL;
        end else begin
          ev_held[best] = 1'b1;
          ev_time[best] = w.tstamp;
          ev_tag[best] = w.tag;
          ev_order[best] = next_stamp;
          next_stamp++;
          held_total++;
        end
      end
      ceq_pkg::KIND_REMOVE: begin
        for (int s = 0; s < SLOTS; s++) begin
          if (ev_held[s] && ev_time[s] == w.tstamp && ev_tag[s] == w.tag &&
              (best < 0 || age(s) > age(best))) best = s;
        end
        if (best < 0) begin
          a.status = ceq_pkg::ST_NOT_FOUND;
        end else begin
          ev_held[best] = 1'b0;
          held_total--;
        end
      end
      ceq_pkg::KIND_POP: begin
        cnt = (count_reg == 0) ? 1 : (count_reg > BUCKETS_MAX) ? BUCKETS_MAX : count_reg;
        f0 = cur_frame;
        r = f0 % cnt;
        for (int s = 0; s < SLOTS; s++) begin
          if (ev_held[s]) begin
            q = ev_time[s] >> width_log2;
            b = q % cnt;
            fb = f0 + ((b + cnt - r) % cnt);
            fr = (q > fb) ? q : fb;
            if (best < 0 || fr < best_fr || (fr == best_fr && (ev_time[s] < ev_time[best] ||
                (ev_time[s] == ev_time[best] && age(s) > age(best))))) begin
              best = s;
              best_fr = fr;
            end
          end
        end
        if (best < 0) begin
          a.status = ceq_pkg::ST_EMPTY;
        end else begin
          a.ptime = ev_time[best];
          a.ptag = ev_tag[best];
          ev_held[best] = 1'b0;
          held_total--;
          cur_frame = best_fr[31:0];
        end
      end
      default: ;
    endcase
    a.size = held_total;
    a.frame = cur_frame;
    return a;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Sample the handshakes; predict on every accepted input word and check every result word.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (awaited.size() == 0) begin
          $display("%0t: unexpected result word, status %0d", $time, out_status);
          errors++;
        end else begin
          answer_t e;
          e = awaited.pop_front();
          check_field("status", e.status, out_status);
          check_field("popped_time", e.ptime, out_popped_time);
          check_field("popped_tag", e.ptag, out_popped_tag);
          check_field("queue_size", e.size, out_queue_size);
          check_field("frame_now", e.frame, out_frame_now);
        end
      end
      if (in_valid && in_ready)
        awaited.insert(awaited.size(),
                       queue_op('{kind: ceq_pkg::kind_t'(in_kind), tstamp: in_event_time,
                                  tag: in_event_tag}));
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      out_ready <= ($urandom_range(0, 99) >= rcv_idle);
      if (!in_valid || in_taken) begin
        if (pending_ops.size() > 0 && $urandom_range(0, 99) >= snd_idle) begin
          op_word_t w;
          w = pending_ops.pop_front();
          in_kind <= w.kind;
          in_event_time <= w.tstamp;
          in_event_tag <= w.tag;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Called only while the block is idle.
  task automatic set_calendar(logic [4:0] w, logic [8:0] c);
    reg_write(ADDR_WIDTH, {27'd0, w});
    reg_write(ADDR_COUNT, {23'd0, c});
    width_log2 = w;
    count_reg = c;
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pending_ops.size() != 0 || in_valid || awaited.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic add_op(ceq_pkg::kind_t k, logic [31:0] t, logic [15:0] g);
    pending_ops.insert(pending_ops.size(), '{kind: k, tstamp: t, tag: g});
    if (k == ceq_pkg::KIND_INSERT) history.insert(history.size(), '{kind: k, tstamp: t, tag: g});
  endtask

  function automatic logic [31:0] pick_time();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'hFFFF_FFFF - $urandom_range(0, 3000);
      2: return $urandom_range(0, 15);
      default: return ($urandom_range(0, 600) << width_log2) + ($urandom() >> (31 - width_log2));
    endcase
  endfunction

  task automatic add_random(int n);
    int roll;
    op_word_t h;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        // A burst of inserts that can run the store into the full condition.
        repeat ($urandom_range(60, 75))
          add_op(ceq_pkg::KIND_INSERT, pick_time(), $urandom_range(0, 7));
        i += 60;
      end else if (roll < 48) begin
        add_op(ceq_pkg::KIND_INSERT, pick_time(),
               ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 7)));
      end else if (roll < 70 && history.size() > 0) begin
        h = history[$urandom_range(0, history.size() - 1)];
        add_op(ceq_pkg::KIND_REMOVE, h.tstamp, h.tag);
      end else if (roll < 74) begin
        add_op(ceq_pkg::KIND_REMOVE, $urandom(), 16'($urandom()));
      end else if (roll < 96) begin
        add_op(ceq_pkg::KIND_POP, $urandom(), 16'($urandom()));
      end else begin
        add_op(ceq_pkg::KIND_NONE, $urandom(), 16'($urandom()));
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = ceq_pkg::KIND_NONE;
    in_event_time = '0;
    in_event_tag = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    cycles = 0;
    snd_idle = 29;
    rcv_idle = 84;
    for (int s = 0; s < SLOTS; s++) ev_held[s] = 1'b0;
    held_total = '0;
    cur_frame = '0;
    next_stamp = '0;
    width_log2 = '0;
    count_reg = 9'd256;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed words under the reset settings.
    add_op(ceq_pkg::KIND_POP, 32'd0, 16'd0);
    add_op(ceq_pkg::KIND_NONE, 32'hFFFF_FFFF, 16'hFFFF);
    add_op(ceq_pkg::KIND_INSERT, 32'd0, 16'd0);
    add_op(ceq_pkg::KIND_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
    add_op(ceq_pkg::KIND_INSERT, 32'd300, 16'h00A5);
    add_op(ceq_pkg::KIND_INSERT, 32'd300, 16'h00A5);
    add_op(ceq_pkg::KIND_INSERT, 32'd44, 16'h5A00);
    add_op(ceq_pkg::KIND_REMOVE, 32'd300, 16'h00A4);
    add_op(ceq_pkg::KIND_REMOVE, 32'd300, 16'h00A5);
    add_op(ceq_pkg::KIND_POP, 32'd0, 16'd0);
    add_op(ceq_pkg::KIND_POP, 32'd0, 16'd0);
    add_op(ceq_pkg::KIND_INSERT, 32'd3, 16'h1234);
    add_op(ceq_pkg::KIND_POP, 32'd0, 16'd0);
    add_op(ceq_pkg::KIND_POP, 32'd0, 16'd0);
    add_op(ceq_pkg::KIND_POP, 32'd0, 16'd0);
    add_op(ceq_pkg::KIND_POP, 32'd0, 16'd0);
    wait_drained();

    set_calendar(5'd3, 9'd16);
    add_random(150);
    // Hold off the sender until every result is back.
    wait_drained();
    set_calendar(5'd24, 9'd1);
    add_random(130);
    wait_drained();

    snd_idle = 84;
    rcv_idle = 29;
    set_calendar(5'd31, 9'd0);
    add_random(140);
    wait_drained();
    set_calendar(5'd0, 9'd511);
    add_random(140);
    wait_drained();

    snd_idle = 0;
    rcv_idle = 0;
    set_calendar(5'd5, 9'd256);
    add_random(150);
    wait_drained();
    set_calendar(5'd0, 9'd7);
    add_random(140);
    wait_drained();
    repeat (500) @(posedge clk);

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> calendar_event_queue.f
src/ceq_pkg.sv
src/ceq_ram.sv
src/ceq_rem.sv
src/calendar_event_queue.sv
verif/calendar_event_queue_tb.sv
